// ----- src/sausb_pkg.sv -----
// ----------------------------------------------------------------------------
// sausb_pkg
// Shared types and constants of the sorted array upper-bound search unit.
// ----------------------------------------------------------------------------
package sausb_pkg;

    localparam int DEPTH_DEF = 1024;
    localparam int VALUE_W   = 32;
    localparam int POS_W     = 11;

    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    typedef struct packed {
        logic                      operation;
        logic                      restart;
        logic signed [VALUE_W-1:0] value;
    } t_in;

    typedef struct packed {
        logic [POS_W-1:0] position;
        logic             overflow;
    } t_out;

endpackage

// ----- src/sausb_store.sv -----
// ----------------------------------------------------------------------------
// sausb_store
// Element store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sausb_store #(
    parameter  int DEPTH = sausb_pkg::DEPTH_DEF,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                                i_clk,
    input  logic                                i_wr_en,
    input  logic [AW-1:0]                       i_wr_addr,
    input  logic signed [sausb_pkg::VALUE_W-1:0] i_wr_data,
    input  logic [AW-1:0]                       i_rd_addr,
    output logic signed [sausb_pkg::VALUE_W-1:0] o_rd_data
);

    logic signed [sausb_pkg::VALUE_W-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rd_data <= mem[i_rd_addr];
    end

endmodule

// ----- src/sorted_array_upper_bound_search_unit.sv -----
// ----------------------------------------------------------------------------
// sorted_array_upper_bound_search_unit
// Holds up to DEPTH ascending signed elements and answers upper-bound searches.
// ----------------------------------------------------------------------------
// An append beat writes the next entry of the element RAM; a full store drops
// it and returns one result beat with the overflow flag. A search beat halves
// [0, count) with one RAM probe per cycle, the RAM's registered read setting
// the pace, and the registered result follows the last probe; an empty array
// is answered at acceptance without a probe. One item is in work at a time;
// the result register drains while the next item is taken. The store needs no
// clearing after reset, since only entries below the count are read.
module sorted_array_upper_bound_search_unit #(
    parameter  int DEPTH = sausb_pkg::DEPTH_DEF,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW    = $clog2(DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  sausb_pkg::t_in   i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output sausb_pkg::t_out  o_out_data
);

    typedef enum logic {
        S_IDLE,
        S_PROBE
    } t_state;

    t_state                               r_state, n_state;
    logic [CW-1:0]                        r_count, n_count;
    logic                                 r_ovf, n_ovf;
    logic [CW-1:0]                        r_lo, n_lo;
    logic [CW-1:0]                        r_hi, n_hi;
    logic [AW-1:0]                        r_mid;
    logic signed [sausb_pkg::VALUE_W-1:0] r_key, n_key;
    logic                                 r_out_valid, n_out_valid;
    sausb_pkg::t_out                      r_out, n_out;

    logic                                 in_acc;
    logic                                 wr_en;
    logic [AW-1:0]                        wr_addr;
    logic [AW-1:0]                        rd_addr;
    logic signed [sausb_pkg::VALUE_W-1:0] rd_data;
    logic [CW:0]                          mid_sum;
    logic [CW-1:0]                        cnt_base;
    logic                                 ovf_base;
    logic                                 le;

    assign o_in_ready  = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign cnt_base = i_in_data.restart ? '0 : r_count;
    assign ovf_base = i_in_data.restart ? 1'b0 : r_ovf;
    assign le       = rd_data <= r_key;
    assign mid_sum  = {1'b0, n_lo} + {1'b0, n_hi};
    assign rd_addr  = AW'(mid_sum[CW:1]);

    sausb_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_in_data.value),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_ovf       = r_ovf;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_key       = r_key;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        wr_en       = 1'b0;
        wr_addr     = AW'(cnt_base);
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    unique case (i_in_data.operation)
                        sausb_pkg::OP_APPEND: begin
                            if (cnt_base == CW'(DEPTH)) begin
                                n_ovf          = 1'b1;
                                n_out_valid    = 1'b1;
                                n_out.position = sausb_pkg::POS_W'(cnt_base);
                                n_out.overflow = 1'b1;
                            end else begin
                                wr_en   = 1'b1;
                                n_count = cnt_base + CW'(1);
                                n_ovf   = ovf_base;
                            end
                        end
                        sausb_pkg::OP_SEARCH: begin
                            n_lo  = '0;
                            n_hi  = r_count;
                            n_key = i_in_data.value;
                            if (r_count == '0) begin
                                n_out_valid    = 1'b1;
                                n_out.position = '0;
                                n_out.overflow = r_ovf;
                            end else begin
                                n_state = S_PROBE;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_PROBE: begin
                if (le) begin
                    n_lo = CW'(r_mid) + CW'(1);
                end else begin
                    n_hi = CW'(r_mid);
                end
                if (n_lo >= n_hi) begin
                    n_state        = S_IDLE;
                    n_out_valid    = 1'b1;
                    n_out.position = sausb_pkg::POS_W'(n_lo);
                    n_out.overflow = r_ovf;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_lo  <= n_lo;
        r_hi  <= n_hi;
        r_mid <= rd_addr;
        r_key <= n_key;
        r_out <= n_out;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("element count exceeds capacity");

    a_probe_interval : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PROBE) |-> (r_lo < r_hi) && (r_hi <= r_count))
        else $error("probe interval empty or beyond count");

    a_probe_no_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PROBE) |-> !r_out_valid)
        else $error("result pending while search in progress");

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sorted array upper-bound search unit. Sorted
// arrays with random content are loaded and searched, with some unsorted and
// noisy traffic mixed in. A scoreboard keeps its own copy of the store and
// predicts every result beat. Sender idling and receiver stalls change from
// phase to phase.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int DEPTH      = sausb_pkg::DEPTH_DEF;
    localparam int IDLE_LIMIT = 2000;

    class upper_bound_scoreboard;
        logic signed [sausb_pkg::VALUE_W-1:0] elements [DEPTH];
        int unsigned                          count = 0;
        logic                                 overflow_seen = 1'b0;
        sausb_pkg::t_out                      pending_answers[$];
        int                                   errors = 0;

        function logic [sausb_pkg::POS_W-1:0] upper_bound_of(
            logic signed [sausb_pkg::VALUE_W-1:0] key);
            int unsigned lo, hi, mid;
            lo = 0;
            hi = count;
            while (lo < hi) begin
                mid = (lo + hi) >> 1;
                if (elements[mid] <= key) lo = mid + 1;
                else hi = mid;
            end
            return sausb_pkg::POS_W'(lo);
        endfunction

        function void take_item(sausb_pkg::t_in beat);
            sausb_pkg::t_out answer;
            if (beat.operation == sausb_pkg::OP_APPEND) begin
                if (beat.restart) begin
                    count = 0;
                    overflow_seen = 1'b0;
                end
                if (count >= DEPTH) begin
                    overflow_seen = 1'b1;
                    answer.position = sausb_pkg::POS_W'(DEPTH);
                    answer.overflow = 1'b1;
                    pending_answers = {pending_answers, answer};
                end else begin
                    elements[count] = beat.value;
                    count++;
                end
            end else begin
                answer.position = upper_bound_of(beat.value);
                answer.overflow = overflow_seen;
                pending_answers = {pending_answers, answer};
            end
        endfunction

        function void check_answer(sausb_pkg::t_out got);
            sausb_pkg::t_out want;
            if (pending_answers.size() == 0) begin
                $error("unexpected result beat: position %0d overflow %0d",
                       got.position, got.overflow);
                errors++;
                return;
            end
            want = pending_answers.pop_front();
            if (got.position !== want.position) begin
                $error("position: expected %0d, actual %0d", want.position, got.position);
                errors++;
            end
            if (got.overflow !== want.overflow) begin
                $error("overflow: expected %0d, actual %0d", want.overflow, got.overflow);
                errors++;
            end
        endfunction
    endclass

    logic            i_clk     = 1'b0;
    logic            i_rst_n   = 1'b0;
    logic            in_valid  = 1'b0;
    logic            in_ready;
    sausb_pkg::t_in  in_data   = '0;
    logic            out_valid;
    logic            out_ready = 1'b0;
    sausb_pkg::t_out out_data;

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int idle_cycles    = 0;
    int sent_items     = 0;
    int loaded[$];

    upper_bound_scoreboard sb;

    sorted_array_upper_bound_search_unit #(.DEPTH(DEPTH)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        out_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_valid && in_ready) sb.take_item(in_data);
            if (out_valid && out_ready) sb.check_answer(out_data);
            if ((in_valid && in_ready) || (out_valid && out_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    task automatic send_beat(input logic op, input logic rst,
                             input logic signed [sausb_pkg::VALUE_W-1:0] val);
        sausb_pkg::t_in beat;
        beat.operation = op;
        beat.restart   = rst;
        beat.value     = val;
        while ($urandom_range(99) < src_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= beat;
        do @(posedge i_clk); while (!in_ready);
        sent_items++;
    endtask

    task automatic append_elem(input int val, input logic rst);
        if (rst) loaded.delete();
        if (loaded.size() < DEPTH) loaded = {loaded, val};
        send_beat(sausb_pkg::OP_APPEND, rst, val);
    endtask

    task automatic find_key(input int key, input logic rst);
        send_beat(sausb_pkg::OP_SEARCH, rst, key);
    endtask

    function automatic int rand_elem();
        case ($urandom_range(3))
            0: return $urandom;
            1: return int'($urandom_range(200)) - 100;
            2: return $urandom_range(1) ? int'(32'h7FFF_FFFF) - int'($urandom_range(3))
                                        : int'(32'h8000_0000) + int'($urandom_range(3));
            default: return int'($urandom_range(2000)) - 1000;
        endcase
    endfunction

    function automatic int pick_key();
        int r;
        int k;
        r = $urandom_range(9);
        if (loaded.size() == 0 || r < 2) return $urandom;
        k = loaded[$urandom_range(loaded.size() - 1)];
        if (r < 6) return k;
        if (r < 8) return k + 1;
        return k - 1;
    endfunction

    task automatic load_array(input int n, input bit ordered);
        int vals[$];
        repeat (n) vals = {vals, rand_elem()};
        if (ordered) vals.sort();
        foreach (vals[i]) append_elem(vals[i], i == 0);
    endtask

    task automatic probe_array(input int n);
        repeat (n) find_key(pick_key(), $urandom_range(7) == 0);
    endtask

    task automatic random_traffic(input int n_items);
        int stop_at;
        stop_at = sent_items + n_items;
        while (sent_items < stop_at) begin
            case ($urandom_range(9))
                7: begin
                    load_array($urandom_range(1, 16), 1'b0);
                    probe_array($urandom_range(1, 5));
                end
                8: begin
                    repeat ($urandom_range(1, 4)) append_elem(rand_elem(), 1'b0);
                    probe_array($urandom_range(1, 4));
                end
                9: begin
                    if ($urandom_range(1)) append_elem($urandom, $urandom_range(1));
                    else find_key($urandom, $urandom_range(1));
                end
                default: begin
                    load_array($urandom_range(1, 24), 1'b1);
                    probe_array($urandom_range(2, 8));
                end
            endcase
        end
    endtask

    initial begin
        sb = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        find_key(0, 1'b0);
        find_key(int'(32'h8000_0000), 1'b1);
        find_key(int'(32'h7FFF_FFFF), 1'b0);
        append_elem(int'(32'h8000_0000), 1'b1);
        append_elem(-5, 1'b0);
        append_elem(0, 1'b0);
        append_elem(0, 1'b0);
        append_elem(7, 1'b0);
        append_elem(int'(32'h7FFF_FFFF), 1'b0);
        find_key(int'(32'h8000_0000), 1'b0);
        find_key(-6, 1'b0);
        find_key(0, 1'b0);
        find_key(1, 1'b0);
        find_key(7, 1'b0);
        find_key(int'(32'h7FFF_FFFF), 1'b0);
        find_key(-1, 1'b0);
        append_elem(10, 1'b1);
        append_elem(-10, 1'b0);
        append_elem(3, 1'b0);
        find_key(0, 1'b0);
        find_key(10, 1'b0);
        append_elem(-1, 1'b1);
        find_key(-1, 1'b1);
        find_key(-2, 1'b0);

        random_traffic(150);

        src_idle_pct   = 52;
        sink_stall_pct = 0;
        random_traffic(150);

        src_idle_pct   = 0;
        sink_stall_pct = 52;
        random_traffic(150);

        src_idle_pct   = 36;
        sink_stall_pct = 36;
        random_traffic(150);

        in_valid <= 1'b0;
        while (sb.pending_answers.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (sb.errors == 0) $display("Simulation PASSED");
        else $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- sorted_array_upper_bound_search_unit.f -----
src/sausb_pkg.sv
src/sausb_store.sv
src/sorted_array_upper_bound_search_unit.sv
bench/tb_top.sv
